FILE: rtl/core/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// shared types and widths for the rgb to hsl pixel pipeline
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned QuoBits  = 8;
  localparam int unsigned SatRemW  = 16;
  localparam int unsigned SatDivW  = 15;
  localparam int unsigned HueRemW  = 19;
  localparam int unsigned HueDivW  = 18;
  localparam int unsigned NumW     = 11;
  localparam int unsigned SumW     = 9;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_e;

  // payload carried through the restoring divider stages
  typedef struct packed {
    logic                 grey;
    logic [PixW-1:0]      light;
    logic [SatRemW-1:0]   sat_rem;
    logic [SatDivW-1:0]   sat_div;
    logic [QuoBits-1:0]   sat_quo;
    logic [HueRemW-1:0]   hue_rem;
    logic [HueDivW-1:0]   hue_div;
    logic [QuoBits-1:0]   hue_quo;
  } hsl_div_t;

endpackage

FILE: rtl/core/rgb_to_hsl_pixel_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_top
// 8-bit rgb pixel to hue, saturation and lightness, each 0..255, truncated
// ----------------------------------------------------------------------------
// usage
//   a pixel beat enters on red_i, green_i, blue_i at a rising edge where
//   start is high and busy is low; busy stays low, so a new pixel may
//   enter on every clock
//   each result beat sits on hue_o, saturation_o, lightness_o for exactly
//   one cycle with done_o high; results leave in input order
//   each accepted pixel passes through 3 prep stages (max/min, numerator
//   and denominator, scaling by 255), 8 restoring divider stages that each
//   settle one quotient bit of hue and saturation side by side, and one
//   output register
//   throughput is one pixel per clock, set by the fully pipelined divider
//   the receiver cannot stall, so nothing holds the pipeline; valid bits
//   travel with each beat
//   reset clears every valid bit and done_o; pixels in flight are dropped
//   a grey pixel (all components equal) gives hue and saturation of zero
// ----------------------------------------------------------------------------
module rgb_to_hsl_pixel_top
  import rgbhsl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [PixW-1:0] red_i,
  input  logic [PixW-1:0] green_i,
  input  logic [PixW-1:0] blue_i,
  output logic            done_o,
  output logic [PixW-1:0] hue_o,
  output logic [PixW-1:0] saturation_o,
  output logic [PixW-1:0] lightness_o
);

  // divider chain: index 0 is the prep output, index QuoBits the last step
  logic [QuoBits:0] div_valid;
  hsl_div_t         div_data [0:QuoBits];

  logic             done_q;
  logic [PixW-1:0]  hue_q, hue_d;
  logic [PixW-1:0]  sat_q, sat_d;
  logic [PixW-1:0]  light_q;

  // the pipeline never pushes back
  assign busy = 1'b0;

  rgbhsl_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (div_valid[0]),
    .data_o  (div_data[0])
  );

  // one quotient bit per stage, msb first
  for (genvar i = 0; i < QuoBits; i++) begin : g_div
    rgbhsl_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[i]),
      .data_i  (div_data[i]),
      .valid_o (div_valid[i+1]),
      .data_o  (div_data[i+1])
    );
  end

  // grey pixel forces hue and saturation to zero (the hue divisor is zero there)
  always_comb begin
    hue_d = div_data[QuoBits].grey ? '0 : div_data[QuoBits].hue_quo;
    sat_d = div_data[QuoBits].grey ? '0 : div_data[QuoBits].sat_quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid[QuoBits];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q   <= hue_d;
    sat_q   <= sat_d;
    light_q <= div_data[QuoBits].light;
  end

  assign done_o       = done_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign lightness_o  = light_q;

  // every accepted pixel comes out as a result beat
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##12 done_o)
    else $error("result beat missing after accepted pixel");

  // no result beat without a matching accepted pixel
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 12))
    else $error("result beat without matching pixel");

  // hue quotient stays below full scale since the numerator is below 6*delta
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hue_o != 8'hFF))
    else $error("hue reached full scale");

  // grey pixel gives zero hue and saturation and its own level as lightness
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && red_i == green_i && green_i == blue_i) |->
      ##12 (hue_o == '0 && saturation_o == '0 && lightness_o == $past(red_i, 12)))
    else $error("grey pixel converted wrongly");

endmodule

FILE: rtl/core/rgbhsl_prep.sv
// ----------------------------------------------------------------------------
// rgbhsl_prep
// three register stages: max/min and sector, hue numerator and sat
// denominator, then scaling by 255 and divisor alignment
// ----------------------------------------------------------------------------
module rgbhsl_prep
  import rgbhsl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [PixW-1:0] red_i,
  input  logic [PixW-1:0] green_i,
  input  logic [PixW-1:0] blue_i,
  output logic            valid_o,
  output hsl_div_t        data_o
);

  // stage a
  logic                   a_valid_q;
  sector_e                a_sector_q, a_sector_d;
  logic [PixW-1:0]        a_delta_q, a_delta_d;
  logic [SumW-1:0]        a_sum_q, a_sum_d;
  logic signed [SumW-1:0] a_diff_q, a_diff_d;

  // stage b
  logic                   b_valid_q;
  logic                   b_grey_q, b_grey_d;
  logic [PixW-1:0]        b_light_q, b_light_d;
  logic [PixW-1:0]        b_delta_q, b_delta_d;
  logic [PixW-1:0]        b_denom_q, b_denom_d;
  logic [NumW-1:0]        b_num_q, b_num_d;

  // stage c
  logic                   c_valid_q;
  hsl_div_t               c_data_q, c_data_d;

  logic [PixW-1:0]        mx, mn;
  logic signed [11:0]     off, num_s;
  logic [11:0]            dlt12;
  logic [SumW-1:0]        denom_hi;
  logic [NumW-1:0]        six_delta;

  // max, min and sector in tie order red, green, blue
  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    a_delta_d = mx - mn;
    a_sum_d   = {1'b0, mx} + {1'b0, mn};
    if (mx == red_i) begin
      a_sector_d = SECT_RED;
      a_diff_d   = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (mx == green_i) begin
      a_sector_d = SECT_GREEN;
      a_diff_d   = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      a_sector_d = SECT_BLUE;
      a_diff_d   = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  // hue numerator with red-sector wrap, sat denominator
  always_comb begin
    dlt12 = {4'd0, a_delta_q};
    case (a_sector_q)
      SECT_RED:   off = a_diff_q[SumW-1] ? $signed((dlt12 << 2) + (dlt12 << 1))
                                         : 12'sd0;
      SECT_GREEN: off = $signed(dlt12 << 1);
      SECT_BLUE:  off = $signed(dlt12 << 2);
      default:    off = 12'sd0;
    endcase
    num_s     = off + {{(12-SumW){a_diff_q[SumW-1]}}, a_diff_q};
    b_num_d   = num_s[NumW-1:0];
    denom_hi  = 9'd510 - a_sum_q;
    b_denom_d = a_sum_q[SumW-1] ? denom_hi[PixW-1:0] : a_sum_q[PixW-1:0];
    b_grey_d  = (a_delta_q == '0);
    b_light_d = a_sum_q[SumW-1:1];
    b_delta_d = a_delta_q;
  end

  // times 255 as shift and subtract, divisors aligned to the top quotient bit
  always_comb begin
    six_delta        = ({3'd0, b_delta_q} << 2) + ({3'd0, b_delta_q} << 1);
    c_data_d.grey    = b_grey_q;
    c_data_d.light   = b_light_q;
    c_data_d.sat_rem = {b_delta_q, 8'd0} - {8'd0, b_delta_q};
    c_data_d.sat_div = {b_denom_q, 7'd0};
    c_data_d.sat_quo = '0;
    c_data_d.hue_rem = {b_num_q, 8'd0} - {8'd0, b_num_q};
    c_data_d.hue_div = {six_delta, 7'd0};
    c_data_d.hue_quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_sector_q <= a_sector_d;
    a_delta_q  <= a_delta_d;
    a_sum_q    <= a_sum_d;
    a_diff_q   <= a_diff_d;
    b_grey_q   <= b_grey_d;
    b_light_q  <= b_light_d;
    b_delta_q  <= b_delta_d;
    b_denom_q  <= b_denom_d;
    b_num_q    <= b_num_d;
    c_data_q   <= c_data_d;
  end

  assign valid_o = c_valid_q;
  assign data_o  = c_data_q;

endmodule

FILE: rtl/core/rgbhsl_div_stage.sv
// ----------------------------------------------------------------------------
// rgbhsl_div_stage
// one restoring division step for hue and saturation, one quotient bit each
// ----------------------------------------------------------------------------
module rgbhsl_div_stage
  import rgbhsl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  hsl_div_t data_i,
  output logic     valid_o,
  output hsl_div_t data_o
);

  logic     valid_q;
  hsl_div_t data_q, data_d;
  logic     sat_ge, hue_ge;

  always_comb begin
    sat_ge = data_i.sat_rem >= {1'b0, data_i.sat_div};
    hue_ge = data_i.hue_rem >= {1'b0, data_i.hue_div};
    data_d         = data_i;
    data_d.sat_rem = sat_ge ? data_i.sat_rem - {1'b0, data_i.sat_div} : data_i.sat_rem;
    data_d.hue_rem = hue_ge ? data_i.hue_rem - {1'b0, data_i.hue_div} : data_i.hue_rem;
    data_d.sat_div = data_i.sat_div >> 1;
    data_d.hue_div = data_i.hue_div >> 1;
    data_d.sat_quo = {data_i.sat_quo[QuoBits-2:0], sat_ge};
    data_d.hue_quo = {data_i.hue_quo[QuoBits-2:0], hue_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: tb/rgb_to_hsl_pixel_top_test.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_top_test
// self-checking bench for the rgb to hsl pixel converter
// ----------------------------------------------------------------------------
// pixels are pushed through the start and rgb inputs, and an in-bench hsl calculator
// queues the hue, saturation and lightness each pixel should produce.
// every done_o beat is checked against the oldest queued triple. a directed
// set covers grey pixels, channel ties, the wrapped red-sector hue and the
// saturation fold at mid lightness; random phases follow with different
// amounts of sender idling. a watchdog ends the run if beats stop moving.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_hsl_pixel_top_test
  import rgbhsl_pkg::*;
();

  localparam int unsigned StallLimit  = 1000;  // cycles with no beat at all
  localparam int unsigned DrainCycles = 16;    // pipeline is 12 deep
  localparam int unsigned PhaseItems  = 475;

  typedef struct packed {
    logic [PixW-1:0] hue;
    logic [PixW-1:0] sat;
    logic [PixW-1:0] light;
  } hsl_t;

  logic            clk_i      = 1'b0;
  logic            rst_ni     = 1'b0;
  logic            pix_start  = 1'b0;
  logic [PixW-1:0] pix_red    = '0;
  logic [PixW-1:0] pix_green  = '0;
  logic [PixW-1:0] pix_blue   = '0;
  logic            busy;
  logic            done_o;
  logic [PixW-1:0] hue_o;
  logic [PixW-1:0] saturation_o;
  logic [PixW-1:0] lightness_o;

  hsl_t        hsl_expected_q[$];
  int unsigned pixels_sent    = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned wrapped_hues   = 0;
  int unsigned grey_pixels    = 0;
  int unsigned stall_cycles   = 0;

  always #2 clk_i = ~clk_i;

  rgb_to_hsl_pixel_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (pix_start),
    .busy         (busy),
    .red_i        (pix_red),
    .green_i      (pix_green),
    .blue_i       (pix_blue),
    .done_o       (done_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .lightness_o  (lightness_o)
  );

  // exact integer hsl, every field is the floor of the true ratio
  function automatic hsl_t predict_hsl(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                                       input logic [PixW-1:0] b);
    int      ri, gi, bi, mx, mn, delta, sum, denom, diff, num;
    sector_e sect;
    hsl_t    res;
    ri = r;
    gi = g;
    bi = b;
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    delta = mx - mn;
    sum   = mx + mn;
    res   = '0;
    res.light = PixW'(sum >> 1);
    if (delta != 0) begin
      // saturation folds around mid lightness
      denom   = (sum <= 255) ? sum : 510 - sum;
      res.sat = PixW'((255 * delta) / denom);
      // ties resolve red first, then green
      if (mx == ri) begin
        sect = SECT_RED;
        diff = gi - bi;
      end else if (mx == gi) begin
        sect = SECT_GREEN;
        diff = bi - ri;
      end else begin
        sect = SECT_BLUE;
        diff = ri - gi;
      end
      // sector weight is 0, 2 or 4 sixths of the circle
      num = 2 * int'(sect) * delta + diff;
      // red sector with green below blue wraps to the top of the circle
      if (num < 0) num += 6 * delta;
      res.hue = PixW'((255 * num) / (6 * delta));
    end
    return res;
  endfunction

  // drives one pixel beat and waits for the edge that takes it
  task automatic send_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                            input logic [PixW-1:0] b);
    hsl_t exp_hsl;
    pix_start <= 1'b1;
    pix_red   <= r;
    pix_green <= g;
    pix_blue  <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    exp_hsl = predict_hsl(r, g, b);
    if (r == g && g == b) grey_pixels++;
    if (r > g && r >= b && g < b) wrapped_hues++;
    hsl_expected_q.push_back(exp_hsl);
    pixels_sent++;
  endtask

  // drops start for a random number of cycles, about idle_pct in a hundred
  task automatic sender_gap(input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      pix_start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
  endtask

  task automatic test_directed;
    send_pixel(8'd0,   8'd0,   8'd0);    // black
    send_pixel(8'd255, 8'd255, 8'd255);  // white
    send_pixel(8'd128, 8'd128, 8'd128);  // mid grey
    send_pixel(8'd255, 8'd0,   8'd0);    // pure primaries
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);    // red sector, wraps just below full turn
    send_pixel(8'd255, 8'd0,   8'd255);  // red/blue tie, wraps
    send_pixel(8'd255, 8'd255, 8'd0);    // red/green tie stays in red sector
    send_pixel(8'd0,   8'd255, 8'd255);  // green/blue tie stays in green sector
    send_pixel(8'd1,   8'd0,   8'd0);    // smallest delta, dark
    send_pixel(8'd255, 8'd254, 8'd254);  // smallest delta, bright
    send_pixel(8'd128, 8'd127, 8'd127);  // sum exactly on the fold
    send_pixel(8'd127, 8'd128, 8'd128);
    send_pixel(8'd128, 8'd128, 8'd127);  // sum also exactly on the fold
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd50,  8'd200, 8'd100);
    send_pixel(8'd100, 8'd50,  8'd200);
    send_pixel(8'h55,  8'hAA,  8'hFF);   // alternating bit patterns
    send_pixel(8'hAA,  8'h55,  8'h00);
    send_pixel(8'hFF,  8'h01,  8'h00);
    pix_start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_random_pixels(input int unsigned count, input int unsigned idle_pct);
    logic [PixW-1:0] r, g, b, base;
    int unsigned     burst_left;
    burst_left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      r = PixW'($urandom);
      g = PixW'($urandom);
      b = PixW'($urandom);
      case ($urandom_range(9))
        0: begin  // grey
          g = r;
          b = r;
        end
        1: begin  // two channels tied
          case ($urandom_range(2))
            0:       g = r;
            1:       b = g;
            default: b = r;
          endcase
        end
        2: begin  // nearly grey, small delta
          base = PixW'($urandom_range(252));
          r = base + PixW'($urandom_range(3));
          g = base + PixW'($urandom_range(3));
          b = base + PixW'($urandom_range(3));
        end
        3: begin  // corner values
          r = ($urandom_range(1) != 0) ? 8'hFF - PixW'($urandom_range(1))
                                       : PixW'($urandom_range(1));
          g = ($urandom_range(1) != 0) ? 8'hFF - PixW'($urandom_range(1))
                                       : PixW'($urandom_range(1));
          b = ($urandom_range(1) != 0) ? 8'hFF - PixW'($urandom_range(1))
                                       : PixW'($urandom_range(1));
        end
        default: ;  // fully random
      endcase
      send_pixel(r, g, b);
      // now and then a back-to-back stretch even in idling phases
      if (burst_left == 0 && $urandom_range(31) == 0) burst_left = $urandom_range(8, 40);
      if (burst_left != 0) burst_left--;
      else sender_gap(idle_pct);
    end
    pix_start <= 1'b0;
    @(posedge clk_i);
  endtask

  // result checker, also feeds the watchdog
  always @(posedge clk_i) begin
    hsl_t exp_hsl;
    if ((pix_start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (rst_ni && done_o) begin
      results_seen++;
      if (hsl_expected_q.size() == 0) begin
        $error("result beat with no pixel outstanding: hue %0d sat %0d light %0d",
               hue_o, saturation_o, lightness_o);
        mismatch_count++;
      end else begin
        exp_hsl = hsl_expected_q.pop_front();
        if (hue_o !== exp_hsl.hue) begin
          $error("hue: expected %0d, got %0d", exp_hsl.hue, hue_o);
          mismatch_count++;
        end
        if (saturation_o !== exp_hsl.sat) begin
          $error("saturation: expected %0d, got %0d", exp_hsl.sat, saturation_o);
          mismatch_count++;
        end
        if (lightness_o !== exp_hsl.light) begin
          $error("lightness: expected %0d, got %0d", exp_hsl.light, lightness_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog, ends the run when beats stop moving
  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("watchdog: no beat for %0d cycles, %0d results outstanding",
             StallLimit, hsl_expected_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    // the receiver cannot stall, so the phases vary only the sender idling
    test_random_pixels(PhaseItems, 0);
    test_random_pixels(PhaseItems, 46);
    test_random_pixels(PhaseItems, 0);
    test_random_pixels(PhaseItems, 20);

    while (hsl_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d pixels, %0d results, %0d grey, %0d with wrapped red hue",
             pixels_sent, results_seen, grey_pixels, wrapped_hues);
    $display("sender idling at 0, 46 and 20 percent, %0d field mismatches", mismatch_count);
    if (mismatch_count == 0 && hsl_expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rgbhsl_pkg.sv
rtl/core/rgbhsl_prep.sv
rtl/core/rgbhsl_div_stage.sv
rtl/core/rgb_to_hsl_pixel_top.sv
tb/rgb_to_hsl_pixel_top_test.sv
